// ===== rtl/core/stereo_dc_agc_soft_clip_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stereo output stage
// Shared helpers for the port-level checker of the block.
// ----------------------------------------------------------------------------
`ifndef STEREO_DC_AGC_SOFT_CLIP_TOP_DEFINES_SVH
`define STEREO_DC_AGC_SOFT_CLIP_TOP_DEFINES_SVH

// Condition in one cycle implies a condition in the next cycle.
`define SDASC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition implies a condition in the same cycle.
`define SDASC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sdasc_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo output stage package
// Widths, register indexes, fixed constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package sdasc_pkg;

    // Serial multiplier operand and product widths.
    localparam int MUL_A_W = 52;
    localparam int MUL_B_W = 29;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 2;

    localparam int COEF_W    = 16;
    localparam int LEVEL_W   = 48;
    localparam int ROOT_W    = 32;
    localparam int RAD_W     = 64;
    localparam int CORDIC_W  = 52;
    localparam int ANGLE_W   = 27;
    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W    = 5;
    localparam int OUT_W     = 16;
    localparam int IDLE_W    = 13;
    localparam int AVG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DC_COEF    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COEF = 1'b1;

    localparam logic [COEF_W-1:0]  COEF_RESET  = 16'd380;
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 48'h0000_4000_0000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 48'hFFFF_FFFF_FFFF;

    // 65534/pi in Q16.
    localparam logic [31:0] POST_SCALE_Q16 = 32'd1367088830;

    // atan(2^-i) in Q24.
    function automatic logic signed [ANGLE_W-1:0] atan_q24(input logic [ITER_W-1:0] i);
        logic signed [ANGLE_W-1:0] v;
        begin
            case (i)
                5'd0:  v = 27'sd13176795;
                5'd1:  v = 27'sd7778716;
                5'd2:  v = 27'sd4110060;
                5'd3:  v = 27'sd2086331;
                5'd4:  v = 27'sd1047214;
                5'd5:  v = 27'sd524117;
                5'd6:  v = 27'sd262123;
                5'd7:  v = 27'sd131069;
                5'd8:  v = 27'sd65536;
                5'd9:  v = 27'sd32768;
                5'd10: v = 27'sd16384;
                5'd11: v = 27'sd8192;
                5'd12: v = 27'sd4096;
                5'd13: v = 27'sd2048;
                5'd14: v = 27'sd1024;
                5'd15: v = 27'sd512;
                5'd16: v = 27'sd256;
                5'd17: v = 27'sd128;
                5'd18: v = 27'sd64;
                5'd19: v = 27'sd32;
                5'd20: v = 27'sd16;
                5'd21: v = 27'sd8;
                5'd22: v = 27'sd4;
                5'd23: v = 27'sd2;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Saturate a 40-bit value to the signed 32-bit range.
    function automatic logic signed [AVG_W-1:0] sat32(input logic signed [39:0] v);
        logic signed [AVG_W-1:0] r;
        begin
            if (v > 40'sh00_7FFF_FFFF)
            begin
                r = 32'sh7FFF_FFFF;
            end
            else if (v < -40'sh00_8000_0000)
            begin
                r = 32'sh8000_0000;
            end
            else
            begin
                r = v[AVG_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sdasc_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample input channel
// Carries one mixed stereo pair or one idle block per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdasc_in_if #(
    parameter int MIX_WIDTH = 20
) ();
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic signed [MIX_WIDTH-1:0]      mix_left;
    logic signed [MIX_WIDTH-1:0]      mix_right;
    logic [sdasc_pkg::IDLE_W-1:0]     idle_samples;

    modport source (output valid, op, mix_left, mix_right, idle_samples, input ready);
    modport sink (input valid, op, mix_left, mix_right, idle_samples, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sdasc_out_if.sv =====
// ----------------------------------------------------------------------------
// Result output channel
// Carries one soft-clipped stereo pair per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdasc_out_if ();
    logic                                valid;
    logic                                ready;
    logic signed [sdasc_pkg::OUT_W-1:0]  out_left;
    logic signed [sdasc_pkg::OUT_W-1:0]  out_right;

    modport source (output valid, out_left, out_right, input ready);
    modport sink (input valid, out_left, out_right, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sdasc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data to write.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdasc_cfg_if ();
    logic                                   valid;
    logic                                   ready;
    logic [sdasc_pkg::CFG_IDX_W-1:0]        index;
    logic [sdasc_pkg::COEF_W-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sdasc_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Signed A times unsigned B, one bit of B per cycle, full product kept.
// ----------------------------------------------------------------------------
`default_nettype none

module sdasc_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [sdasc_pkg::MUL_A_W-1:0]  a,
    input  logic [sdasc_pkg::MUL_B_W-1:0]         b,
    output logic                                  done,
    output logic signed [sdasc_pkg::MUL_P_W-1:0]  prod
);
    localparam int AW    = sdasc_pkg::MUL_A_W;
    localparam int BW    = sdasc_pkg::MUL_B_W;
    localparam int CNT_W = $clog2(BW + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [AW-1:0]  a_reg;
    logic [BW-1:0]         b_reg;
    logic signed [AW+1:0]  hi_reg;
    logic [BW-1:0]         lo_reg;
    logic signed [AW+1:0]  addend;
    logic signed [AW+1:0]  sum;

    // One partial product is added per cycle, then the pair shifts right.
    assign addend = b_reg[0] ? {{2{a_reg[AW-1]}}, a_reg} : '0;
    assign sum    = hi_reg + addend;

    // Step counter and completion pulse.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(BW);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and accumulator shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= b;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg  <= {1'b0, b_reg[BW-1:1]};
            hi_reg <= sum >>> 1;
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ===== rtl/core/sdasc_isqrt.sv =====
// ----------------------------------------------------------------------------
// Digit-serial square root
// Floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdasc_isqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [sdasc_pkg::RAD_W-1:0]      radicand,
    output logic                             done,
    output logic [sdasc_pkg::ROOT_W-1:0]     root
);
    localparam int RW    = sdasc_pkg::ROOT_W;
    localparam int VW    = sdasc_pkg::RAD_W;
    localparam int CNT_W = $clog2(RW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VW-1:0]     v_reg;
    logic [RW+1:0]     rem_reg;
    logic [RW-1:0]     root_reg;
    logic [RW+3:0]     rem_sh;
    logic [RW+3:0]     trial;
    logic              fits;

    // Bring down two radicand bits and try the next root bit.
    assign rem_sh = {rem_reg, v_reg[VW-1:VW-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RW);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Radicand, remainder and root shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[VW-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= (RW+2)'(rem_sh - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sdasc_cordic.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Computes atan(y/x) in Q24, one rotation per cycle, clamped at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sdasc_cordic (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [sdasc_pkg::CORDIC_W-1:0]   x0,
    input  logic signed [sdasc_pkg::CORDIC_W-1:0]   y0,
    output logic                                    done,
    output logic [sdasc_pkg::ANGLE_W-2:0]           angle
);
    localparam int CW = sdasc_pkg::CORDIC_W;
    localparam int ZW = sdasc_pkg::ANGLE_W;
    localparam int IW = sdasc_pkg::ITER_W;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [IW-1:0]         iter_reg, iter_next;
    logic signed [CW-1:0]  x_reg;
    logic signed [CW-1:0]  y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic signed [ZW-1:0]  rot;

    // Shifted terms for this rotation.
    assign dx  = y_reg >>> iter_reg;
    assign dy  = x_reg >>> iter_reg;
    assign rot = sdasc_pkg::atan_q24(iter_reg);

    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
        end
        else if (busy_reg)
        begin
            iter_next = iter_reg + 1'b1;
            if (iter_reg == IW'(sdasc_pkg::CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    // Rotate toward the x axis by the sign of y.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x0;
            y_reg <= y0;
            z_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[CW-1])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + rot;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - rot;
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg[ZW-1] ? '0 : z_reg[ZW-2:0];

endmodule

`default_nettype wire

// ===== rtl/core/stereo_dc_agc_soft_clip_top.sv =====
// ----------------------------------------------------------------------------
// Stereo DC blocker, gain control and soft limiter
// Output stage of a stereo mixer built from bit-serial arithmetic units.
// ----------------------------------------------------------------------------
// The block works on one item at a time and takes a new item only when the
// previous one has left the arithmetic units. A stereo pair makes four passes
// through the 29-step bit-serial multipliers (DC averages, squares, level
// update, output scaling), 32 steps of the square root and 24 CORDIC
// rotations, both channels running side by side. An idle item gives no
// result. A finished pair waits in
// the output register, so the next item can be accepted before it is taken.
// The configuration channel is always ready and must only be written while
// the block is idle.
`default_nettype none

module stereo_dc_agc_soft_clip_top #(
    parameter int MIX_WIDTH = 20
) (
    input  logic           clk,
    input  logic           rst_n,
    sdasc_in_if.sink       samples,
    sdasc_out_if.source    results,
    sdasc_cfg_if.sink      cfg
);
    localparam int AW = sdasc_pkg::MUL_A_W;
    localparam int BW = sdasc_pkg::MUL_B_W;
    localparam int PW = sdasc_pkg::MUL_P_W;
    localparam int CW = sdasc_pkg::COEF_W;
    localparam int LW = sdasc_pkg::LEVEL_W;
    localparam int VW = sdasc_pkg::AVG_W;
    localparam int OW = sdasc_pkg::OUT_W;
    localparam int ZW = sdasc_pkg::ANGLE_W;
    localparam int XW = sdasc_pkg::CORDIC_W;
    localparam int RW = sdasc_pkg::ROOT_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DC     = 4'd1;
    localparam logic [3:0] ST_SQ     = 4'd2;
    localparam logic [3:0] ST_LV     = 4'd3;
    localparam logic [3:0] ST_SQRT   = 4'd4;
    localparam logic [3:0] ST_COR    = 4'd5;
    localparam logic [3:0] ST_PS     = 4'd6;
    localparam logic [3:0] ST_OUT    = 4'd7;
    localparam logic [3:0] ST_ID_AVG = 4'd8;
    localparam logic [3:0] ST_ID_LVL = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic                   mul_start_reg, mul_start_next;
    logic                   sqrt_start_reg, sqrt_start_next;
    logic                   cor_start_reg, cor_start_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CW-1:0]          dc_coef_reg;
    logic [CW-1:0]          lv_coef_reg;
    logic signed [VW-1:0]   avg_l_reg;
    logic signed [VW-1:0]   avg_r_reg;
    logic [LW-1:0]          level_reg;

    logic signed [AW-1:0]   d_l_reg;
    logic signed [AW-1:0]   d_r_reg;
    logic [BW-1:0]          m_dc_reg;
    logic [BW-1:0]          m_lv_reg;
    logic [AW-1:0]          p_reg;
    logic [RW-1:0]          root_reg;
    logic [ZW-2:0]          z_l_reg;
    logic [ZW-2:0]          z_r_reg;
    logic signed [OW-1:0]   q_l_reg;
    logic signed [OW-1:0]   q_r_reg;
    logic signed [OW-1:0]   out_l_reg;
    logic signed [OW-1:0]   out_r_reg;

    logic                   in_acc;
    logic                   out_load;
    logic signed [MIX_WIDTH-1:0] mix_l;
    logic signed [MIX_WIDTH-1:0] mix_r;
    logic signed [AW-1:0]   x_l_ext;
    logic signed [AW-1:0]   x_r_ext;
    logic signed [AW-1:0]   avg_l_ext;
    logic signed [AW-1:0]   avg_r_ext;
    logic signed [AW-1:0]   d_l_new;
    logic signed [AW-1:0]   d_r_new;
    logic [BW-1:0]          m_dc_new;
    logic [BW-1:0]          m_lv_new;

    logic signed [AW-1:0]   e_l;
    logic signed [AW-1:0]   e_r;
    logic signed [AW-1:0]   e_abs_l;
    logic signed [AW-1:0]   e_abs_r;
    logic signed [AW-1:0]   avg_abs_l;
    logic signed [AW-1:0]   avg_abs_r;
    logic [AW-1:0]          lvl_ext;
    logic                   p_ge;
    logic [AW-1:0]          lv_diff;
    logic signed [AW-1:0]   d_abs_l;
    logic signed [AW-1:0]   d_abs_r;

    logic signed [AW-1:0]   mul_a_l;
    logic signed [AW-1:0]   mul_a_r;
    logic [BW-1:0]          mul_b_l;
    logic [BW-1:0]          mul_b_r;
    logic                   mul_done_l;
    logic                   mul_done_r;
    logic signed [PW-1:0]   prod_l;
    logic signed [PW-1:0]   prod_r;
    logic                   sqrt_done;
    logic [RW-1:0]          sqrt_root;
    logic                   cor_done_l;
    logic                   cor_done_r;
    logic [ZW-2:0]          cor_z_l;
    logic [ZW-2:0]          cor_z_r;
    logic signed [XW-1:0]   cor_x0;
    logic signed [XW-1:0]   cor_y0_l;
    logic signed [XW-1:0]   cor_y0_r;

    logic signed [39:0]     dc_sum_l;
    logic signed [39:0]     dc_sum_r;
    logic [43:0]            lv_inc;
    logic [52:0]            lv_new;
    logic [LW-1:0]          lv_clamped;
    logic [16:0]            q_raw_l;
    logic [16:0]            q_raw_r;
    logic [OW-1:0]          q_sat_l;
    logic [OW-1:0]          q_sat_r;
    logic [35:0]            id_dec_l;
    logic [35:0]            id_dec_r;
    logic signed [39:0]     id_sum_l;
    logic signed [39:0]     id_sum_r;
    logic [AW-1:0]          id_lv_dec;
    logic [LW-1:0]          id_lv_new;

    // Handshakes.
    assign samples.ready = (state_reg == ST_IDLE);
    assign in_acc        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || results.ready);

    // Sample entry: d = x*2^12 - average, idle decay factors.
    assign mix_l     = samples.mix_left;
    assign mix_r     = samples.mix_right;
    assign x_l_ext   = {{(AW-MIX_WIDTH){mix_l[MIX_WIDTH-1]}}, mix_l};
    assign x_r_ext   = {{(AW-MIX_WIDTH){mix_r[MIX_WIDTH-1]}}, mix_r};
    assign avg_l_ext = {{(AW-VW){avg_l_reg[VW-1]}}, avg_l_reg};
    assign avg_r_ext = {{(AW-VW){avg_r_reg[VW-1]}}, avg_r_reg};
    assign d_l_new   = {x_l_ext[AW-13:0], 12'b0} - avg_l_ext;
    assign d_r_new   = {x_r_ext[AW-13:0], 12'b0} - avg_r_ext;
    assign m_dc_new  = samples.idle_samples * dc_coef_reg;
    assign m_lv_new  = samples.idle_samples * lv_coef_reg;

    // Magnitudes and level difference for the multiplier passes.
    assign e_l       = d_l_reg >>> 12;
    assign e_r       = d_r_reg >>> 12;
    assign e_abs_l   = e_l[AW-1] ? -e_l : e_l;
    assign e_abs_r   = e_r[AW-1] ? -e_r : e_r;
    assign avg_abs_l = avg_l_ext[AW-1] ? -avg_l_ext : avg_l_ext;
    assign avg_abs_r = avg_r_ext[AW-1] ? -avg_r_ext : avg_r_ext;
    assign d_abs_l   = d_l_reg[AW-1] ? -d_l_reg : d_l_reg;
    assign d_abs_r   = d_r_reg[AW-1] ? -d_r_reg : d_r_reg;
    assign lvl_ext   = {{(AW-LW){1'b0}}, level_reg};
    assign p_ge      = (p_reg >= lvl_ext);
    assign lv_diff   = p_ge ? (p_reg - lvl_ext) : (lvl_ext - p_reg);

    // Multiplier operand selection by phase.
    always_comb
    begin
        mul_a_l = '0;
        mul_a_r = '0;
        mul_b_l = '0;
        mul_b_r = '0;
        case (state_reg)
            ST_DC:
            begin
                mul_a_l = d_l_reg;
                mul_a_r = d_r_reg;
                mul_b_l = {{(BW-CW){1'b0}}, dc_coef_reg};
                mul_b_r = {{(BW-CW){1'b0}}, dc_coef_reg};
            end
            ST_SQ:
            begin
                mul_a_l = e_abs_l;
                mul_a_r = e_abs_r;
                mul_b_l = e_abs_l[BW-1:0];
                mul_b_r = e_abs_r[BW-1:0];
            end
            ST_LV:
            begin
                mul_a_l = $signed(lv_diff);
                mul_b_l = {{(BW-CW){1'b0}}, lv_coef_reg};
            end
            ST_PS:
            begin
                mul_a_l = $signed({{(AW-32){1'b0}}, sdasc_pkg::POST_SCALE_Q16});
                mul_a_r = $signed({{(AW-32){1'b0}}, sdasc_pkg::POST_SCALE_Q16});
                mul_b_l = {{(BW-ZW+1){1'b0}}, z_l_reg};
                mul_b_r = {{(BW-ZW+1){1'b0}}, z_r_reg};
            end
            ST_ID_AVG:
            begin
                mul_a_l = avg_abs_l;
                mul_a_r = avg_abs_r;
                mul_b_l = m_dc_reg;
                mul_b_r = m_dc_reg;
            end
            ST_ID_LVL:
            begin
                mul_a_l = $signed(lvl_ext);
                mul_b_l = m_lv_reg;
            end
            default:
            begin
            end
        endcase
    end

    sdasc_mul u_mul_l (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_l),
        .b     (mul_b_l),
        .done  (mul_done_l),
        .prod  (prod_l)
    );

    sdasc_mul u_mul_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_r),
        .b     (mul_b_r),
        .done  (mul_done_r),
        .prod  (prod_r)
    );

    sdasc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand ({level_reg, 16'b0}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // CORDIC starts from x = root*2^16 and y = |d|*2^12.
    assign cor_x0   = $signed({{(XW-RW-16){1'b0}}, root_reg, 16'b0});
    assign cor_y0_l = {d_abs_l[XW-13:0], 12'b0};
    assign cor_y0_r = {d_abs_r[XW-13:0], 12'b0};

    sdasc_cordic u_cordic_l (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start_reg),
        .x0    (cor_x0),
        .y0    (cor_y0_l),
        .done  (cor_done_l),
        .angle (cor_z_l)
    );

    sdasc_cordic u_cordic_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start_reg),
        .x0    (cor_x0),
        .y0    (cor_y0_r),
        .done  (cor_done_r),
        .angle (cor_z_r)
    );

    // DC average update: avg + floor(d*coef/2^24).
    assign dc_sum_l = {{8{avg_l_reg[VW-1]}}, avg_l_reg} + prod_l[63:24];
    assign dc_sum_r = {{8{avg_r_reg[VW-1]}}, avg_r_reg} + prod_r[63:24];

    // Level update with magnitude-truncated increment, then clamp.
    assign lv_inc = prod_l[67:24];
    assign lv_new = p_ge ? ({5'b0, level_reg} + {9'b0, lv_inc})
                         : ({5'b0, level_reg} - {9'b0, lv_inc});
    always_comb
    begin
        if (lv_new < {5'b0, sdasc_pkg::LEVEL_FLOOR})
        begin
            lv_clamped = sdasc_pkg::LEVEL_FLOOR;
        end
        else if (lv_new > {5'b0, sdasc_pkg::LEVEL_MAX})
        begin
            lv_clamped = sdasc_pkg::LEVEL_MAX;
        end
        else
        begin
            lv_clamped = lv_new[LW-1:0];
        end
    end

    // Output scaling: angle*65534/pi, clamp to 32767.
    assign q_raw_l = prod_l[56:40];
    assign q_raw_r = prod_r[56:40];
    assign q_sat_l = (q_raw_l > 17'd32767) ? 16'd32767 : q_raw_l[OW-1:0];
    assign q_sat_r = (q_raw_r > 17'd32767) ? 16'd32767 : q_raw_r[OW-1:0];

    // Idle decay of averages toward zero.
    assign id_dec_l = prod_l[60:25];
    assign id_dec_r = prod_r[60:25];
    assign id_sum_l = avg_l_reg[VW-1]
                      ? ({{8{avg_l_reg[VW-1]}}, avg_l_reg} + $signed({4'b0, id_dec_l}))
                      : ({{8{avg_l_reg[VW-1]}}, avg_l_reg} - $signed({4'b0, id_dec_l}));
    assign id_sum_r = avg_r_reg[VW-1]
                      ? ({{8{avg_r_reg[VW-1]}}, avg_r_reg} + $signed({4'b0, id_dec_r}))
                      : ({{8{avg_r_reg[VW-1]}}, avg_r_reg} - $signed({4'b0, id_dec_r}));

    // Idle decay of the level, stopping at the floor.
    assign id_lv_dec = prod_l[76:25];
    always_comb
    begin
        if ((id_lv_dec >= lvl_ext) ||
            ((lvl_ext - id_lv_dec) < {{(AW-LW){1'b0}}, sdasc_pkg::LEVEL_FLOOR}))
        begin
            id_lv_new = sdasc_pkg::LEVEL_FLOOR;
        end
        else
        begin
            id_lv_new = level_reg - id_lv_dec[LW-1:0];
        end
    end

    // Phase sequencer.
    always_comb
    begin
        state_next      = state_reg;
        mul_start_next  = 1'b0;
        sqrt_start_next = 1'b0;
        cor_start_next  = 1'b0;
        out_valid_next  = out_valid_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next     = samples.op ? ST_ID_AVG : ST_DC;
                    mul_start_next = 1'b1;
                end
            end
            ST_DC:
            begin
                if (mul_done_l)
                begin
                    state_next     = ST_SQ;
                    mul_start_next = 1'b1;
                end
            end
            ST_SQ:
            begin
                if (mul_done_l)
                begin
                    state_next     = ST_LV;
                    mul_start_next = 1'b1;
                end
            end
            ST_LV:
            begin
                if (mul_done_l)
                begin
                    state_next      = ST_SQRT;
                    sqrt_start_next = 1'b1;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next     = ST_COR;
                    cor_start_next = 1'b1;
                end
            end
            ST_COR:
            begin
                if (cor_done_l)
                begin
                    state_next     = ST_PS;
                    mul_start_next = 1'b1;
                end
            end
            ST_PS:
            begin
                if (mul_done_l)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            ST_ID_AVG:
            begin
                if (mul_done_l)
                begin
                    state_next     = ST_ID_LVL;
                    mul_start_next = 1'b1;
                end
            end
            ST_ID_LVL:
            begin
                if (mul_done_l)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            cor_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            dc_coef_reg    <= sdasc_pkg::COEF_RESET;
            lv_coef_reg    <= sdasc_pkg::COEF_RESET;
            avg_l_reg      <= '0;
            avg_r_reg      <= '0;
            level_reg      <= sdasc_pkg::LEVEL_FLOOR;
        end
        else
        begin
            state_reg      <= state_next;
            mul_start_reg  <= mul_start_next;
            sqrt_start_reg <= sqrt_start_next;
            cor_start_reg  <= cor_start_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    sdasc_pkg::REG_DC_COEF:    dc_coef_reg <= cfg.data;
                    sdasc_pkg::REG_LEVEL_COEF: lv_coef_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == ST_DC) && mul_done_l)
            begin
                avg_l_reg <= sdasc_pkg::sat32(dc_sum_l);
                avg_r_reg <= sdasc_pkg::sat32(dc_sum_r);
            end
            if ((state_reg == ST_ID_AVG) && mul_done_l)
            begin
                avg_l_reg <= sdasc_pkg::sat32(id_sum_l);
                avg_r_reg <= sdasc_pkg::sat32(id_sum_r);
            end
            if ((state_reg == ST_LV) && mul_done_l)
            begin
                level_reg <= lv_clamped;
            end
            if ((state_reg == ST_ID_LVL) && mul_done_l)
            begin
                level_reg <= id_lv_new;
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            d_l_reg  <= d_l_new;
            d_r_reg  <= d_r_new;
            m_dc_reg <= m_dc_new;
            m_lv_reg <= m_lv_new;
        end
        if ((state_reg == ST_SQ) && mul_done_l)
        begin
            p_reg <= prod_l[AW-1:0] + prod_r[AW-1:0];
        end
        if ((state_reg == ST_SQRT) && sqrt_done)
        begin
            root_reg <= sqrt_root;
        end
        if ((state_reg == ST_COR) && cor_done_l)
        begin
            z_l_reg <= cor_z_l;
            z_r_reg <= cor_z_r;
        end
        if ((state_reg == ST_PS) && mul_done_l)
        begin
            q_l_reg <= d_l_reg[AW-1] ? -$signed(q_sat_l) : $signed(q_sat_l);
            q_r_reg <= d_r_reg[AW-1] ? -$signed(q_sat_r) : $signed(q_sat_r);
        end
        if (out_load)
        begin
            out_l_reg <= q_l_reg;
            out_r_reg <= q_r_reg;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_left  = out_l_reg;
    assign results.out_right = out_r_reg;

    // The right-hand units run in lockstep with the left ones.
    logic lanes_done_unused;
    assign lanes_done_unused = mul_done_r ^ cor_done_r;

endmodule

`default_nettype wire

// ===== rtl/core/sdasc_chk.sv =====
// ----------------------------------------------------------------------------
// Port checker for the stereo output stage
// Watches the top level's handshakes and results over time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_dc_agc_soft_clip_top_defines.svh"

module sdasc_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [sdasc_pkg::OUT_W-1:0]  out_left,
    input logic signed [sdasc_pkg::OUT_W-1:0]  out_right
);
    // One item is worked on at a time.
    `SDASC_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "item accepted while busy")

    // A result never appears in the cycle right after an accept.
    `SDASC_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result too early")

    // The limiter never reaches the most negative code.
    `SDASC_ASSERT_NOW(a_out_range, clk, rst_n, out_valid, (out_left != -16'sd32768) && (out_right != -16'sd32768), "output out of range")

    // A stalled item stays and holds its value.
    `SDASC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `SDASC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_left) && $stable(out_right), "result changed while stalled")

endmodule

bind stereo_dc_agc_soft_clip_top sdasc_chk u_sdasc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_left  (results.out_left),
    .out_right (results.out_right)
);

`default_nettype wire

// ===== tb/tb_stereo_dc_agc_soft_clip_top.sv =====
// ----------------------------------------------------------------------------
// Stereo output stage testbench
// Drives stereo pairs and idle blocks into the DC blocker, gain control and
// soft limiter, predicts every soft-clipped pair in fixed point and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stereo_dc_agc_soft_clip_top;
    import sdasc_pkg::*;

    localparam int MIXW = 20;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam logic OP_PAIR = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    typedef struct packed {
        logic                   op;
        logic signed [MIXW-1:0] left;
        logic signed [MIXW-1:0] right;
        logic [IDLE_W-1:0]      idle_n;
    } mix_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } clip_pair_t;

    logic clk;
    logic rst_n;

    sdasc_in_if #(.MIX_WIDTH(MIXW)) samples ();
    sdasc_out_if results ();
    sdasc_cfg_if cfg ();

    stereo_dc_agc_soft_clip_top #(.MIX_WIDTH(MIXW)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples),
        .results(results),
        .cfg(cfg)
    );

    // Predictor state.
    longint unsigned dc_coef;
    longint unsigned lvl_coef;
    longint          avg_l;
    longint          avg_r;
    longint unsigned level;

    mix_item_t  pending_items[$];
    clip_pair_t expected_pairs[$];
    int         mismatches;
    int         stall_cycles;
    bit         timed_out;

    // Floor division by a power of two.
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    // floor(v*m/2^s) without overflowing 64 bits.
    function automatic longint unsigned mul_shr(input longint unsigned v,
                                                input longint unsigned m, input int s);
        longint unsigned lowmask;
        lowmask = (64'd1 << s) - 1;
        return (v >> s) * m + (((v & lowmask) * m) >> s);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint atan_step(input int i);
        longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                          262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                          1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    // Soft-limit a DC-free value in Q.12 against the root of the level.
    function automatic logic [OUT_W-1:0] soft_limit(input longint d,
                                                    input longint unsigned s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint unsigned mag;
        longint unsigned q;
        bit neg;
        neg = d < 0;
        mag = neg ? longint'(-d) : longint'(d);
        x = longint'(s << 16);
        y = longint'(mag << 12);
        z = 0;
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
        end
        if (z < 0)
            z = 0;
        q = (longint'(z) * 64'd1367088830) >> 40;
        if (q > 32767)
            q = 32767;
        return neg ? OUT_W'(-longint'(q)) : OUT_W'(q);
    endfunction

    function automatic longint fade_average(input longint avg, input longint unsigned m);
        longint unsigned mag;
        longint dec;
        mag = (avg < 0) ? longint'(-avg) : longint'(avg);
        dec = longint'(mul_shr(mag, m, 25));
        return clamp32((avg < 0) ? avg + dec : avg - dec);
    endfunction

    // Advance the predictor by one item, queueing the expected pair if any.
    task automatic predict_item(input mix_item_t it);
        longint          dl;
        longint          dr;
        longint          el;
        longint          er;
        longint unsigned p;
        longint unsigned dec;
        longint unsigned n;
        longint unsigned s;
        clip_pair_t      pr;
        if (it.op == OP_IDLE)
        begin
            n = it.idle_n;
            avg_l = fade_average(avg_l, n * dc_coef);
            avg_r = fade_average(avg_r, n * dc_coef);
            dec = mul_shr(level, n * lvl_coef, 25);
            if (dec >= level || level - dec < 64'h4000_0000)
                level = 64'h4000_0000;
            else
                level = level - dec;
            return;
        end
        dl = longint'(it.left) * 4096 - avg_l;
        dr = longint'(it.right) * 4096 - avg_r;
        avg_l = clamp32(avg_l + floor_shr(dl * longint'(dc_coef), 24));
        avg_r = clamp32(avg_r + floor_shr(dr * longint'(dc_coef), 24));
        el = floor_shr(dl, 12);
        er = floor_shr(dr, 12);
        p = longint'(el * el) + longint'(er * er);
        if (p >= level)
            level = level + mul_shr(p - level, lvl_coef, 24);
        else
            level = level - mul_shr(level - p, lvl_coef, 24);
        if (level < 64'h4000_0000)
            level = 64'h4000_0000;
        if (level > 64'hFFFF_FFFF_FFFF)
            level = 64'hFFFF_FFFF_FFFF;
        s = int_sqrt(level << 16);
        pr.left = soft_limit(dl, s);
        pr.right = soft_limit(dr, s);
        expected_pairs.push_back(pr);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sample driver: random gap before each item, predicts on acceptance.
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (samples.valid && samples.ready)
            begin
                samples.valid <= 1'b0;
                send_gap = $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0)
                    send_gap = 0;
            end
            else if (!samples.valid && pending_items.size() > 0)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else
                begin
                    samples.valid <= 1'b1;
                    samples.op <= pending_items[0].op;
                    samples.mix_left <= pending_items[0].left;
                    samples.mix_right <= pending_items[0].right;
                    samples.idle_samples <= pending_items[0].idle_n;
                end
            end
        end
    end

    // Acceptance of samples, sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && samples.valid && samples.ready)
            predict_item(pending_items.pop_front());
    end

    // Result monitor and random back-pressure.
    int recv_wait = 0;
    always @(posedge clk)
    begin
        clip_pair_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pair L=%0d R=%0d", results.out_left,
                             results.out_right);
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (want.left !== results.out_left || want.right !== results.out_right)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pair mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                                 want.left, want.right, results.out_left,
                                 results.out_right);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (results.valid && results.ready)
            begin
                results.ready <= 1'b0;
                recv_wait = $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0)
                    recv_wait = 0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
            end
            else
            begin
                results.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            stall_cycles = 0;
        else if (pending_items.size() > 0 || expected_pairs.size() > 0)
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb_stereo_dc_agc_soft_clip_top NOT OK");
            $finish;
        end
    end

    // Write one register while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] v);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == REG_DC_COEF)
            dc_coef = v;
        else
            lvl_coef = v;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_pairs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic mix_item_t pair_item(input int l, input int r);
        mix_item_t it;
        it.op = OP_PAIR;
        it.left = l[MIXW-1:0];
        it.right = r[MIXW-1:0];
        it.idle_n = IDLE_W'($urandom);
        return it;
    endfunction

    function automatic mix_item_t idle_item(input int n);
        mix_item_t it;
        it.op = OP_IDLE;
        it.left = MIXW'($urandom);
        it.right = MIXW'($urandom);
        it.idle_n = n[IDLE_W-1:0];
        return it;
    endfunction

    function automatic int rand_mix();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 524287 : -524288;
            1: return int'($urandom_range(0, 200)) - 100;
            2: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 1048575)) - 524288;
        endcase
    endfunction

    // Fill a phase of random items; most are pairs, some idle blocks.
    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_items.push_back(idle_item($urandom_range(0, 1) ?
                    int'($urandom_range(0, 4096)) : int'($urandom_range(0, 40))));
            else if ($urandom_range(0, 7) == 0)
                pending_items.push_back(pair_item(rand_mix(), rand_mix()));
            else
                pending_items.push_back(pair_item(rand_mix(), rand_mix()));
        end
    endtask

    // Main sequence.
    initial
    begin
        mismatches = 0;
        stall_cycles = 0;
        timed_out = 1'b0;
        dc_coef = COEF_RESET;
        lvl_coef = COEF_RESET;
        avg_l = 0;
        avg_r = 0;
        level = 64'h4000_0000;
        samples.valid = 1'b0;
        samples.op = OP_PAIR;
        samples.mix_left = '0;
        samples.mix_right = '0;
        samples.idle_samples = '0;
        results.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_DC_COEF;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, both operations, idle corner cases at reset values.
        pending_items.push_back(pair_item(0, 0));
        pending_items.push_back(pair_item(524287, -524288));
        pending_items.push_back(pair_item(-524288, 524287));
        pending_items.push_back(pair_item(-1, 1));
        pending_items.push_back(idle_item(0));
        pending_items.push_back(idle_item(4096));
        pending_items.push_back(pair_item(524287, 524287));
        pending_items.push_back(pair_item(-524288, -524288));
        pending_items.push_back(idle_item(1));
        pending_items.push_back(pair_item(12345, -54321));
        pending_items.push_back(idle_item(8191));
        wait_idle();

        // Largest coefficients: averages overshoot and saturate on idle decay.
        write_reg(REG_DC_COEF, 16'hFFFF);
        write_reg(REG_LEVEL_COEF, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            pending_items.push_back(pair_item(524287, -524288));
        pending_items.push_back(idle_item(4096));
        pending_items.push_back(pair_item(0, 0));
        pending_items.push_back(idle_item(4096));
        pending_items.push_back(pair_item(-524288, 524287));
        random_phase(150);
        wait_idle();

        // Smallest coefficients.
        write_reg(REG_DC_COEF, 16'd1);
        write_reg(REG_LEVEL_COEF, 16'd1);
        random_phase(150);
        wait_idle();

        // Random coefficient settings.
        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_DC_COEF, COEF_W'($urandom_range(1, 65535)));
            write_reg(REG_LEVEL_COEF, COEF_W'($urandom_range(1, 65535)));
            random_phase(150);
            wait_idle();
        end

        if (mismatches == 0 && !timed_out)
            $display("tb_stereo_dc_agc_soft_clip_top OK");
        else
            $display("tb_stereo_dc_agc_soft_clip_top NOT OK");
        $finish;
    end

    // Leftover expectations after a long stall add nothing to the mismatch count.
    always @(posedge clk)
    begin
        if (rst_n && expected_pairs.size() > 0 && pending_items.size() == 0
            && stall_cycles > DRAIN_CYCLES * 10)
            mismatches = mismatches + 0;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/sdasc_pkg.sv
rtl/core/sdasc_in_if.sv
rtl/core/sdasc_out_if.sv
rtl/core/sdasc_cfg_if.sv
rtl/core/sdasc_mul.sv
rtl/core/sdasc_isqrt.sv
rtl/core/sdasc_cordic.sv
rtl/core/stereo_dc_agc_soft_clip_top.sv
rtl/core/sdasc_chk.sv
tb/tb_stereo_dc_agc_soft_clip_top.sv
